@@ src/sha_message_padder_top_defines.svh @@
// Assertion macros for the message padder checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SHA_MESSAGE_PADDER_TOP_DEFINES_SVH
`define SHA_MESSAGE_PADDER_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define SHAPAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define SHAPAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/shapad_pkg.sv @@
// Shared types and constants of the message padder.
// No dependencies.
`default_nettype none

package shapad_pkg;

    // cmd codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [8:0] BLK_NARROW = 9'd64;
    localparam logic [8:0] BLK_WIDE   = 9'd128;
    localparam logic [8:0] RSV_NARROW = 9'd8;
    localparam logic [8:0] RSV_WIDE   = 9'd16;

    // result of one byte push
    typedef struct packed {
        logic        word_done;
        logic        block_end;
        logic [31:0] word;
    } push_res_t;

    // pad sequencer status toward the datapath
    typedef struct packed {
        logic       busy;
        logic       last;
        logic [7:0] pad_byte;
    } seq_stat_t;

endpackage

`default_nettype wire

@@ src/shapad_push.sv @@
// Byte packer: absorbs one byte into the partial word and byte count.
// Depends on shapad_pkg.
`default_nettype none

module shapad_push
    import shapad_pkg::*;
(
    input  wire logic [31:0] count,
    input  wire logic [23:0] partial,
    input  wire logic [7:0]  byte_in,
    input  wire logic        wide,
    output logic [31:0]      count_next,
    output logic [23:0]      partial_next,
    output push_res_t        res
);

    logic [31:0] acc;

    always_comb
    begin
        acc           = {partial, byte_in};
        count_next    = count + 32'd1;
        res.word_done = (count[1:0] == 2'b11);
        res.word      = acc;
        // block boundary from the low count bits under the current mode
        res.block_end = res.word_done &&
                        (wide ? (count_next[6:0] == 7'd0) : (count_next[5:0] == 6'd0));
        partial_next  = res.word_done ? 24'd0 : acc[23:0];
    end

endmodule

`default_nettype wire

@@ src/shapad_seq.sv @@
// Pad sequencer: sizes the pad run and feeds one pad byte per step.
// Depends on shapad_pkg.
`default_nettype none

module shapad_seq
    import shapad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] count_in,
    input  wire logic        wide,
    input  wire logic        step,
    output seq_stat_t        stat
);

    typedef enum logic {ST_IDLE, ST_PAD} state_t;

    state_t      state_reg, state_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic        first_reg, first_next;
    logic [31:0] bits_reg, bits_next;

    logic [8:0]  last_pos;
    logic [8:0]  blk;
    logic [8:0]  thr;
    logic [8:0]  padn;

    always_comb
    begin
        last_pos = wide ? {2'b00, count_in[6:0]} : {3'b000, count_in[5:0]};
        blk      = wide ? BLK_WIDE : BLK_NARROW;
        thr      = blk - (wide ? RSV_WIDE : RSV_NARROW);
        // second block when the length field would not fit
        padn     = (last_pos < thr) ? (blk - last_pos) : ({blk[7:0], 1'b0} - last_pos);
    end

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        first_next     = first_reg;
        bits_next      = bits_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next     = ST_PAD;
                    remaining_next = padn[7:0];
                    first_next     = 1'b1;
                    bits_next      = {count_in[28:0], 3'b000};
                end
            end
            ST_PAD:
            begin
                if (step)
                begin
                    first_next     = 1'b0;
                    remaining_next = remaining_reg - 8'd1;
                    if (remaining_reg == 8'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remaining_reg <= 8'd0;
            first_reg     <= 1'b0;
            bits_reg      <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            first_reg     <= first_next;
            bits_reg      <= bits_next;
        end
    end

    // marker first, zeros, then the bit count MSB first in the last four bytes
    always_comb
    begin
        stat.busy     = (state_reg == ST_PAD);
        stat.last     = (remaining_reg == 8'd1);
        stat.pad_byte = 8'h00;
        if (first_reg)
        begin
            stat.pad_byte = PAD_MARK;
        end
        else if (remaining_reg <= 8'd4)
        begin
            case (remaining_reg[1:0])
                2'b00:   stat.pad_byte = bits_reg[31:24];
                2'b11:   stat.pad_byte = bits_reg[23:16];
                2'b10:   stat.pad_byte = bits_reg[15:8];
                2'b01:   stat.pad_byte = bits_reg[7:0];
                default: stat.pad_byte = 8'h00;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/sha_message_padder_top.sv @@
// Message padder top level: byte packer, pad sequencer and output register.
// Depends on shapad_pkg, shapad_push, shapad_seq.
//
//  channel | signals                                        | dir | beat
//  --------+------------------------------------------------+-----+---------------------
//  input   | in_valid, in_stall, cmd, data_byte             | in  | one byte or finish
//  output  | out_valid, out_stall, word, block_end,         | out | one 32-bit word
//          | message_end, run_last                          |     |
//  config  | cfg_we, cfg_wdata                              | in  | wide_block register
//
// Output: a data byte is taken whenever in_stall is low; a word beat leaves from the output
// register the cycle after its fourth byte is taken.
// Finish: the pad run pushes one byte per cycle, unless stalled, through the shared byte
// packer, a pad of 9 to 144 bytes, and in_stall stays high throughout.
// Stalls: a pad byte that completes a word waits while the output register is
// full and stalled; the input is stalled likewise.
// Reset clears byte count, partial word, mode register and the output valid.
`default_nettype none

module sha_message_padder_top
    import shapad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  data_byte,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      word,
    output logic             block_end,
    output logic             message_end,
    output logic             run_last,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    logic        wide_reg;
    logic [31:0] count_reg, count_next;
    logic [23:0] partial_reg, partial_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] word_reg;
    logic        block_end_reg;
    logic        message_end_reg;
    logic        run_last_reg;

    logic [31:0] push_count;
    logic [23:0] push_partial;
    logic [7:0]  push_byte;
    push_res_t   push_res;
    seq_stat_t   seq_stat;

    logic out_busy;
    logic accept;
    logic do_append;
    logic do_start;
    logic do_step;
    logic push_en;
    logic load;
    logic pad_done;

    // output register holds a word that the sink has not taken yet
    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = seq_stat.busy || out_busy;
    assign accept    = in_valid && !in_stall;
    assign do_append = accept && (cmd == CMD_APPEND);
    assign do_start  = accept && (cmd == CMD_FINISH);
    // a pad byte that would complete a word needs a free output register
    assign do_step   = seq_stat.busy && !(push_res.word_done && out_busy);
    assign push_en   = do_append || do_step;
    assign load      = push_en && push_res.word_done;
    assign pad_done  = do_step && seq_stat.last;

    assign push_byte = seq_stat.busy ? seq_stat.pad_byte : data_byte;

    shapad_push u_push (
        .count        (count_reg),
        .partial      (partial_reg),
        .byte_in      (push_byte),
        .wide         (wide_reg),
        .count_next   (push_count),
        .partial_next (push_partial),
        .res          (push_res)
    );

    shapad_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (do_start),
        .count_in (count_reg),
        .wide     (wide_reg),
        .step     (do_step),
        .stat     (seq_stat)
    );

    always_comb
    begin
        count_next   = count_reg;
        partial_next = partial_reg;
        if (pad_done)
        begin
            // message closed: ready for the next one
            count_next   = 32'd0;
            partial_next = 24'd0;
        end
        else if (push_en)
        begin
            count_next   = push_count;
            partial_next = push_partial;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg      <= 1'b0;
            count_reg     <= 32'd0;
            partial_reg   <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wide_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg        <= push_res.word;
            block_end_reg   <= push_res.block_end;
            message_end_reg <= pad_done;
            run_last_reg    <= do_append || pad_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word        = word_reg;
    assign block_end   = block_end_reg;
    assign message_end = message_end_reg;
    assign run_last    = run_last_reg;

endmodule

`default_nettype wire

@@ src/shapad_checker.sv @@
// Port-level checker for the message padder, bound to the top level.
// Depends on shapad_pkg, sha_message_padder_top_defines.svh and sha_message_padder_top.
`default_nettype none
`include "sha_message_padder_top_defines.svh"

module shapad_checker
    import shapad_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        cmd,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] word,
    input wire logic        message_end,
    input wire logic        block_end,
    input wire logic        run_last
);

    // the final word closes a block and the finish run
    `SHAPAD_ASSERT_NOW(a_msg_end_closes, out_valid && message_end, block_end && run_last, "message end without block end or run last")

    // a finish always starts a pad run, which stalls the input
    `SHAPAD_ASSERT_NEXT(a_finish_busy, in_valid && !in_stall && (cmd == CMD_FINISH), in_stall, "input not stalled after finish")

    // stalled word beat holds
    `SHAPAD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(word), "stalled output beat changed")

endmodule

bind sha_message_padder_top shapad_checker u_shapad_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word        (word),
    .message_end (message_end),
    .block_end   (block_end),
    .run_last    (run_last)
);

`default_nettype wire
